/* src/wsc_pkg.sv */
`timescale 1ns / 1ps

package wsc_pkg;

	// Field widths
	localparam int MODE_W   = 2;
	localparam int REG_W    = 5;
	localparam int DATA_W   = 8;
	localparam int SAMPLE_W = 4;
	localparam int FREQ_W   = 11;
	localparam int TIMER_W  = 12;
	localparam int LEVEL_W  = 2;
	localparam int WAVE_BYTES = 16;
	localparam int WADDR_W  = 4;

	// Access modes
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

	// Register map
	localparam logic [REG_W-1:0] REG_DAC       = 5'd0;
	localparam logic [REG_W-1:0] REG_LENGTH    = 5'd1;
	localparam logic [REG_W-1:0] REG_LEVEL     = 5'd2;
	localparam logic [REG_W-1:0] REG_FREQ_LO   = 5'd3;
	localparam logic [REG_W-1:0] REG_CONTROL   = 5'd4;
	localparam logic [REG_W-1:0] REG_WAVE0     = 5'd5;
	localparam logic [REG_W-1:0] REG_WAVE_LAST = 5'd20;

	// Output level codes
	localparam logic [LEVEL_W-1:0] LEVEL_MUTE    = 2'd0;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 2'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_HALF    = 2'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_QUARTER = 2'd3;

	localparam logic [DATA_W-1:0] READ_OPEN = 8'hFF;

	// Period is (2048 - f) * 2 ticks; the timer holds period - 1,
	// which is 4095 - 2f and always fits 12 bits.
	function automatic logic [TIMER_W-1:0] timer_reload(input logic [FREQ_W-1:0] f);
		timer_reload = 12'hFFF - {f, 1'b0};
	endfunction

	// Volume shift applied to a fetched nibble
	function automatic logic [SAMPLE_W-1:0] level_shift(input logic [SAMPLE_W-1:0] nib,
			input logic [LEVEL_W-1:0] level);
		case (level)
			LEVEL_MUTE:    level_shift = '0;
			LEVEL_FULL:    level_shift = nib;
			LEVEL_HALF:    level_shift = nib >> 1;
			LEVEL_QUARTER: level_shift = nib >> 2;
			default:       level_shift = '0;
		endcase
	endfunction

endpackage

/* src/wsc_if.sv */
`timescale 1ns / 1ps

// Access channel: one tick, register write or register read per transfer
interface wsc_item_if;
	logic                      valid;
	logic                      ready;
	logic [wsc_pkg::MODE_W-1:0] mode;
	logic [wsc_pkg::REG_W-1:0]  reg_select;
	logic [wsc_pkg::DATA_W-1:0] write_data;

	modport source (output valid, mode, reg_select, write_data, input ready);
	modport sink   (input valid, mode, reg_select, write_data, output ready);
endinterface

// Result channel: channel output, enable flag and read byte
interface wsc_result_if;
	logic                        valid;
	logic                        ready;
	logic [wsc_pkg::SAMPLE_W-1:0] sample_out;
	logic                        channel_on;
	logic [wsc_pkg::DATA_W-1:0]   read_data;

	modport source (output valid, sample_out, channel_on, read_data, input ready);
	modport sink   (input valid, sample_out, channel_on, read_data, output ready);
endinterface

/* src/wavetable_sound_channel.sv */
`timescale 1ns / 1ps

// Wavetable sound channel: 16-byte wave RAM holding WAVE_SAMPLES 4-bit samples
// (high nibble first), played at a period of (2048 - frequency) * 2 ticks and
// scaled by the output level. Each transfer on "item" is one tick, one register
// write or one register read, and gives exactly one transfer on "result" with
// the state after that access. The state update and the result register sit
// behind one level of logic, and a new item is taken every cycle as long as
// the result register is empty or being drained. The length byte is stored
// but not counted.
module wavetable_sound_channel #(
	parameter int WAVE_SAMPLES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	wsc_item_if.sink     item,
	wsc_result_if.source result
);
	import wsc_pkg::*;

	localparam int IDX_W = $clog2(WAVE_SAMPLES);

	// Channel state
	logic [DATA_W-1:0]   wave_q    [WAVE_BYTES];
	logic [DATA_W-1:0]   wave_rd_q [WAVE_BYTES];
	logic [FREQ_W-1:0]   freq_q, freq_n;
	logic [LEVEL_W-1:0]  level_q, level_n;
	logic                dac_q, dac_n;
	logic                active_q, active_n;
	logic                lsel_q, lsel_n;
	logic [DATA_W-1:0]   length_q, length_n;
	logic [IDX_W-1:0]    idx_q, idx_n;
	logic [SAMPLE_W-1:0] sample_q, sample_n;
	logic [TIMER_W-1:0]  timer_q, timer_n;

	// Result register
	logic                res_valid_q;
	logic [SAMPLE_W-1:0] res_sample_q;
	logic                res_on_q;
	logic [DATA_W-1:0]   res_rd_q;

	logic                accept;
	logic                wave_we;
	logic [WADDR_W-1:0]  wave_addr;
	logic [IDX_W:0]      idx_inc;
	logic [IDX_W-1:0]    idx_adv;
	logic [6:0]          idx_ext;
	logic [DATA_W-1:0]   fetch_byte;
	logic [SAMPLE_W-1:0] fetch_nib;
	logic [FREQ_W-1:0]   ctrl_freq;
	logic [DATA_W-1:0]   rd_n;
	logic                wave_sel;

	assign item.ready = !res_valid_q || result.ready;
	assign accept     = item.valid && item.ready;

	assign wave_sel  = (item.reg_select >= REG_WAVE0) && (item.reg_select <= REG_WAVE_LAST);
	assign wave_addr = WADDR_W'(item.reg_select - REG_WAVE0);
	assign wave_we   = accept && (item.mode == MODE_WRITE) && wave_sel;

	// Next sample index with wrap, and the nibble it selects
	assign idx_inc    = {1'b0, idx_q} + (IDX_W+1)'(1);
	assign idx_adv    = (idx_inc >= (IDX_W+1)'(WAVE_SAMPLES)) ? '0 : idx_inc[IDX_W-1:0];
	assign idx_ext    = 7'(idx_adv);
	assign fetch_byte = wave_q[idx_ext[4:1]];
	assign fetch_nib  = idx_adv[0] ? fetch_byte[3:0] : fetch_byte[7:4];

	assign ctrl_freq = {item.write_data[2:0], freq_q[7:0]};

	// State update for one access
	always_comb begin
		freq_n   = freq_q;
		level_n  = level_q;
		dac_n    = dac_q;
		active_n = active_q;
		lsel_n   = lsel_q;
		length_n = length_q;
		idx_n    = idx_q;
		sample_n = sample_q;
		timer_n  = timer_q;
		rd_n     = '0;
		case (item.mode)
			MODE_TICK: begin
				if (active_q && dac_q) begin
					if (timer_q == '0) begin
						timer_n  = timer_reload(freq_q);
						idx_n    = idx_adv;
						sample_n = level_shift(fetch_nib, level_q);
					end else begin
						timer_n = timer_q - TIMER_W'(1);
					end
				end
			end
			MODE_WRITE: begin
				case (item.reg_select)
					REG_DAC:     dac_n    = item.write_data[7];
					REG_LENGTH:  length_n = item.write_data;
					REG_LEVEL:   level_n  = item.write_data[6:5];
					REG_FREQ_LO: freq_n   = {freq_q[10:8], item.write_data};
					REG_CONTROL: begin
						freq_n = ctrl_freq;
						lsel_n = item.write_data[6];
						if (item.write_data[7]) begin
							timer_n  = timer_reload(ctrl_freq);
							active_n = dac_q;
						end
					end
					default: ;
				endcase
			end
			MODE_READ: begin
				case (item.reg_select)
					REG_LEVEL:   rd_n = {1'b0, level_q, 5'b0};
					REG_CONTROL: rd_n = {1'b0, lsel_q, 6'b0};
					default:     rd_n = wave_sel ? wave_rd_q[wave_addr] : READ_OPEN;
				endcase
			end
			default: ;
		endcase
	end

	// Control and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q   <= '0;
			level_q  <= '0;
			dac_q    <= 1'b0;
			active_q <= 1'b0;
			lsel_q   <= 1'b0;
			length_q <= '0;
			idx_q    <= '0;
			sample_q <= '0;
			timer_q  <= '0;
		end else if (accept) begin
			freq_q   <= freq_n;
			level_q  <= level_n;
			dac_q    <= dac_n;
			active_q <= active_n;
			lsel_q   <= lsel_n;
			length_q <= length_n;
			idx_q    <= idx_n;
			sample_q <= sample_n;
			timer_q  <= timer_n;
		end
	end

	// Wave RAM: one copy for sample fetch, one for bus reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WAVE_BYTES; i++) begin
				wave_q[i]    <= '0;
				wave_rd_q[i] <= '0;
			end
		end else if (wave_we) begin
			wave_q[wave_addr]    <= item.write_data;
			wave_rd_q[wave_addr] <= item.write_data;
		end
	end

	// Result register; loads on every item transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_sample_q <= sample_n;
			res_on_q     <= active_n;
			res_rd_q     <= rd_n;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.sample_out = res_sample_q;
	assign result.channel_on = res_on_q;
	assign result.read_data  = res_rd_q;

endmodule

/* src/wsc_checker.sv */
`timescale 1ns / 1ps

module wsc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [wsc_pkg::SAMPLE_W-1:0] sample_out,
	input logic                        channel_on,
	input logic [wsc_pkg::DATA_W-1:0]   read_data
);
	import wsc_pkg::*;

	// Every item transfer shows a result on the next cycle
	a_item_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("item transfer without a following result");

	// An empty result register never blocks the access side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item side stalled with no result pending");

	// A stalled result stays offered
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_payload_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(sample_out) && $stable(channel_on) && $stable(read_data))
		else $error("result payload changed while stalled");

endmodule

bind wavetable_sound_channel wsc_checker u_wsc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.sample_out (result.sample_out),
	.channel_on (result.channel_on),
	.read_data  (result.read_data)
);

/* bench/wavetable_sound_channel_tb.sv */
`timescale 1ns / 1ps

module wavetable_sound_channel_tb;
	import wsc_pkg::*;

	localparam int WAVE_SAMPLES = 32;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;	// unused access mode
	localparam logic [REG_W-1:0] REG_UNUSED = 5'd31;	// unmapped register number
	localparam logic [REG_W-1:0] REG_WAVE1 = REG_WAVE0 + 5'd1;
	localparam int PHASE_ITEMS = 106;
	localparam int LONG_HOLD = 60;
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_nib;
		logic                active_flag;
		logic [DATA_W-1:0]   read_byte;
	} chan_result_t;

	typedef struct packed {
		logic [MODE_W-1:0] acc_mode;
		logic [REG_W-1:0]  sel;
		logic [DATA_W-1:0] data;
		logic              typed;
		chan_result_t      want;
	} access_row_t;

	logic clk;
	logic arst_n;

	wsc_item_if   item_ch ();
	wsc_result_if result_ch ();

	wavetable_sound_channel #(.WAVE_SAMPLES(WAVE_SAMPLES)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// Predicted channel state
	logic [DATA_W-1:0]   wave_ram [WAVE_BYTES];
	logic [FREQ_W-1:0]   freq_q;
	logic [LEVEL_W-1:0]  level_q;
	logic                dac_on;
	logic                chan_active;
	logic                len_sel;
	logic [DATA_W-1:0]   len_byte;
	logic [4:0]          sample_idx;
	logic [SAMPLE_W-1:0] cur_sample;
	logic [TIMER_W-1:0]  timer_q;

	chan_result_t expected_results [$];
	int mismatch_count;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int holds_served;
	int hold_left;

	int send_idle_by_phase [4] = '{0, 69, 0, 25};
	int recv_stall_by_phase [4] = '{0, 0, 69, 25};

	// Directed accesses; typed rows carry a result readable straight off the spec
	localparam int DIRECTED_ROWS = 26;
	access_row_t directed_rows [DIRECTED_ROWS] = '{
		'{MODE_READ,  REG_DAC,       8'h00, 1'b1, '{4'h0, 1'b0, 8'hFF}},
		'{MODE_READ,  REG_LEVEL,     8'h00, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_READ,  REG_CONTROL,   8'h00, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_READ,  REG_WAVE0,     8'h00, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_NONE,  REG_UNUSED,    8'hFF, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_WRITE, REG_UNUSED,    8'hFF, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_READ,  REG_UNUSED,    8'h00, 1'b1, '{4'h0, 1'b0, 8'hFF}},
		'{MODE_WRITE, REG_WAVE0,     8'hF0, 1'b0, '0},
		'{MODE_WRITE, REG_WAVE1,     8'h5A, 1'b0, '0},
		'{MODE_WRITE, REG_WAVE_LAST, 8'hFF, 1'b0, '0},
		'{MODE_READ,  REG_WAVE_LAST, 8'h00, 1'b1, '{4'h0, 1'b0, 8'hFF}},
		'{MODE_WRITE, REG_LEVEL,     8'h20, 1'b0, '0},
		'{MODE_WRITE, REG_LENGTH,    8'hFF, 1'b0, '0},
		'{MODE_READ,  REG_LENGTH,    8'h00, 1'b1, '{4'h0, 1'b0, 8'hFF}},
		'{MODE_WRITE, REG_FREQ_LO,   8'hFF, 1'b0, '0},
		// trigger with the DAC off leaves the channel disabled
		'{MODE_WRITE, REG_CONTROL,   8'hC7, 1'b1, '{4'h0, 1'b0, 8'h00}},
		'{MODE_READ,  REG_CONTROL,   8'h00, 1'b1, '{4'h0, 1'b0, 8'h40}},
		'{MODE_WRITE, REG_DAC,       8'h80, 1'b0, '0},
		'{MODE_WRITE, REG_CONTROL,   8'h87, 1'b1, '{4'h0, 1'b1, 8'h00}},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b0, '0},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b0, '0},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b0, '0},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b0, '0},
		// DAC off: channel stays on, ticks do nothing
		'{MODE_WRITE, REG_DAC,       8'h00, 1'b0, '0},
		'{MODE_TICK,  REG_DAC,       8'h00, 1'b0, '0}
	};

	// Clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Timeout
	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	// Timer reload: period is (2048 - f) * 2 ticks, timer keeps period - 1
	function automatic logic [TIMER_W-1:0] period_reload(input logic [FREQ_W-1:0] f);
		logic [TIMER_W:0] period;
		period = (13'd2048 - {2'b00, f}) << 1;
		period_reload = period[TIMER_W-1:0] - 1'b1;
	endfunction

	// Apply one access to the predicted state and return the result it yields
	function automatic chan_result_t channel_step(input logic [MODE_W-1:0] acc_mode,
			input logic [REG_W-1:0] sel, input logic [DATA_W-1:0] data);
		chan_result_t res;
		logic [DATA_W-1:0] byte_val;
		logic [SAMPLE_W-1:0] nib;
		logic [REG_W-1:0] offset;
		res.read_byte = '0;
		offset = sel - REG_WAVE0;
		case (acc_mode)
			MODE_TICK: begin
				if (chan_active && dac_on) begin
					if (timer_q == '0) begin
						timer_q = period_reload(freq_q);
						sample_idx = (sample_idx == WAVE_SAMPLES - 1) ? 5'd0 : sample_idx + 1'b1;
						byte_val = wave_ram[sample_idx[4:1]];
						// even index plays the high nibble
						nib = sample_idx[0] ? byte_val[3:0] : byte_val[7:4];
						case (level_q)
							LEVEL_MUTE:    cur_sample = '0;
							LEVEL_FULL:    cur_sample = nib;
							LEVEL_HALF:    cur_sample = nib >> 1;
							default:       cur_sample = nib >> 2;
						endcase
					end else begin
						timer_q = timer_q - 1'b1;
					end
				end
			end
			MODE_WRITE: begin
				case (sel)
					REG_DAC:     dac_on = data[7];
					REG_LENGTH:  len_byte = data;
					REG_LEVEL:   level_q = data[6:5];
					REG_FREQ_LO: freq_q[7:0] = data;
					REG_CONTROL: begin
						freq_q[10:8] = data[2:0];
						len_sel = data[6];
						if (data[7]) begin
							timer_q = period_reload(freq_q);
							chan_active = dac_on;
						end
					end
					default: begin
						if (sel >= REG_WAVE0 && sel <= REG_WAVE_LAST)
							wave_ram[offset[3:0]] = data;
					end
				endcase
			end
			MODE_READ: begin
				case (sel)
					REG_LEVEL:   res.read_byte = {1'b0, level_q, 5'b0};
					REG_CONTROL: res.read_byte = {1'b0, len_sel, 6'b0};
					default: begin
						if (sel >= REG_WAVE0 && sel <= REG_WAVE_LAST)
							res.read_byte = wave_ram[offset[3:0]];
						else
							res.read_byte = READ_OPEN;
					end
				endcase
			end
			default: ;
		endcase
		res.sample_nib = cur_sample;
		res.active_flag = chan_active;
		return res;
	endfunction

	// Offer one access, wait for the transfer, then log its expected result
	task automatic send_access(input logic [MODE_W-1:0] acc_mode, input logic [REG_W-1:0] sel,
			input logic [DATA_W-1:0] data, input logic typed, input chan_result_t want);
		chan_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.mode       <= acc_mode;
		item_ch.reg_select <= sel;
		item_ch.write_data <= data;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predicted = channel_step(acc_mode, sel, data);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Random access, mostly ticks and writes that keep the channel running fast
	task automatic send_random_access();
		logic [MODE_W-1:0] m;
		logic [REG_W-1:0] s;
		logic [DATA_W-1:0] d;
		int pick;
		pick = $urandom_range(99);
		s = REG_W'($urandom_range(31));
		d = DATA_W'($urandom);
		if (pick < 55) begin
			m = MODE_TICK;
		end else if (pick < 78) begin
			m = MODE_WRITE;
			case ($urandom_range(9))
				0: begin
					s = REG_DAC;
					d[7] = ($urandom_range(9) < 8);
				end
				1: begin
					s = REG_CONTROL;
					if ($urandom_range(3) != 0)
						d[2:0] = 3'b111;
					d[7] = ($urandom_range(2) != 0);
				end
				2: begin
					s = REG_FREQ_LO;
					if ($urandom_range(3) != 0)
						d[7:4] = 4'hF;
				end
				3: s = REG_LEVEL;
				4, 5, 6: s = REG_WAVE0 + REG_W'($urandom_range(15));
				7: s = REG_LENGTH;
				default: ;	// any register number, unused ones included
			endcase
		end else if (pick < 95) begin
			m = MODE_READ;
		end else begin
			m = MODE_NONE;
		end
		send_access(m, s, d, 1'b0, '0);
	endtask

	// Drop valid and let every outstanding result drain
	task automatic wait_all_results();
		item_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: check each transfer, then pick ready for the next edge
	initial result_ch.ready = 1'b0;
	always @(posedge clk) begin : result_monitor
		chan_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: sample %0h on %0b read %02h", $time,
					result_ch.sample_out, result_ch.channel_on, result_ch.read_data);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				if (result_ch.sample_out !== want.sample_nib) begin
					$display("%0t: sample_out expected %0h actual %0h", $time,
						want.sample_nib, result_ch.sample_out);
					mismatch_count++;
				end
				if (result_ch.channel_on !== want.active_flag) begin
					$display("%0t: channel_on expected %0b actual %0b", $time,
						want.active_flag, result_ch.channel_on);
					mismatch_count++;
				end
				if (result_ch.read_data !== want.read_byte) begin
					$display("%0t: read_data expected %02h actual %02h", $time,
						want.read_byte, result_ch.read_data);
					mismatch_count++;
				end
			end
		end
		// long hold-off on request, otherwise random stalls
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Stimulus and verdict
	initial begin
		item_ch.valid      = 1'b0;
		item_ch.mode       = MODE_TICK;
		item_ch.reg_select = '0;
		item_ch.write_data = '0;
		arst_n             = 1'b0;
		mismatch_count     = 0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		hold_requests      = 0;
		holds_served       = 0;
		hold_left          = 0;
		for (int i = 0; i < WAVE_BYTES; i++)
			wave_ram[i] = '0;
		freq_q      = '0;
		level_q     = '0;
		dac_on      = 1'b0;
		chan_active = 1'b0;
		len_sel     = 1'b0;
		len_byte    = '0;
		sample_idx  = '0;
		cur_sample  = '0;
		timer_q     = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_access(directed_rows[i].acc_mode, directed_rows[i].sel, directed_rows[i].data,
				directed_rows[i].typed, directed_rows[i].want);
		end
		wait_all_results();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_idle_by_phase[p];
			recv_stall_pct = recv_stall_by_phase[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver backs off while transfers keep coming, so the input stalls
				if (p == 0 && n == 30)
					hold_requests <= hold_requests + 1;
				send_random_access();
			end
			wait_all_results();
		end

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
